// ----- rtl/frt_pkg.sv -----
// Shared constants and types for the frequency rank tracker.
package frt_pkg;

   localparam int NumValuesDef = 1024;
   localparam int MaxCountDef  = 1024;
   localparam int BucketLenDef = 32;

   localparam int ReqTypeW = 2;
   localparam int ValueIdW = 10;
   localparam int RankW    = 11;
   localparam int CountW   = 11;

   localparam logic [ReqTypeW-1:0] REQ_ADD    = 2'd0;
   localparam logic [ReqTypeW-1:0] REQ_REMOVE = 2'd1;
   localparam logic [ReqTypeW-1:0] REQ_QUERY  = 2'd2;
   // Unused request code; the block answers it without changing anything.
   localparam logic [ReqTypeW-1:0] REQ_SPARE  = 2'd3;

   // One finished request as the engine reports it.
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [CountW-1:0] kth_count;
      logic [CountW-1:0] distinct_now;
   } result_type;

endpackage

// ----- rtl/frt_count_mem.sv -----
// Memory of per-value occurrence counts, cleared by a sweep after reset.
module frt_count_mem #(
   parameter int NUM_VALUES = frt_pkg::NumValuesDef,
   parameter int AW         = $clog2(NUM_VALUES),
   parameter int DW         = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   import frt_pkg::*;

   logic [DW-1:0] mem [NUM_VALUES];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/frt_hist_mem.sv -----
// Memory of the count histogram, one entry per nonzero count.
module frt_hist_mem #(
   parameter int DEPTH = frt_pkg::MaxCountDef,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   import frt_pkg::*;

   logic [DW-1:0] mem [DEPTH];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/frequency_rank_tracker_unit.sv -----
// Top level of the frequency rank tracker: sequencer, bucket sums and memories.
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid in the last cycle that busy is
// high, and the next request can be taken at the end of the cycle after it.
// After reset the block clears its count and histogram memories in a sweep
// with busy high. An add or remove reads the count word, then reads the old
// count's histogram entry and writes it back less one, then reads the new
// count's entry and writes it back plus one, using the separate read and write
// ports of each memory. Only the new entry is updated when the count rises from
// zero, only the old one when it falls to zero, and neither when the request is
// ignored. A query walks the bucket sums until the rank falls inside a bucket,
// then reads and compares the histogram entries of that bucket one at a time
// and then reports; a query that cannot be answered goes straight to the report.
// The bucket walk and the serial histogram walk make up most of a query.
// The receiver cannot stall; results are never held back.
module frequency_rank_tracker_unit #(
   parameter int NUM_VALUES = frt_pkg::NumValuesDef,
   parameter int MAX_COUNT  = frt_pkg::MaxCountDef,
   parameter int BUCKET_LEN = frt_pkg::BucketLenDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [frt_pkg::ReqTypeW-1:0] req_type,
   input  logic [frt_pkg::ValueIdW-1:0] req_value_id,
   input  logic [frt_pkg::RankW-1:0]    req_rank,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [frt_pkg::CountW-1:0]   rsp_kth_count,
   output logic [frt_pkg::CountW-1:0]   rsp_distinct_now
);
   import frt_pkg::*;

   localparam int NumBuckets = (MAX_COUNT + BUCKET_LEN - 1) / BUCKET_LEN;
   localparam int VaW  = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
   localparam int HaW  = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam int BaW  = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int OfW  = (BUCKET_LEN > 1) ? $clog2(BUCKET_LEN) : 1;
   localparam int CW   = $clog2(MAX_COUNT + 1);
   localparam int SumW = $clog2(NUM_VALUES + 1);
   localparam int ClrN = (NUM_VALUES > MAX_COUNT) ? NUM_VALUES : MAX_COUNT;
   localparam int ClrW = $clog2(ClrN + 1);
   localparam int IdW  = (VaW > ValueIdW) ? VaW + 1 : ValueIdW + 1;

   // Sequencer states.
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CRD   = 4'd2;
   localparam logic [3:0] S_OLD   = 4'd3;
   localparam logic [3:0] S_OLDW  = 4'd4;
   localparam logic [3:0] S_NEW   = 4'd5;
   localparam logic [3:0] S_NEWW  = 4'd6;
   localparam logic [3:0] S_BWALK = 4'd7;
   localparam logic [3:0] S_HRD   = 4'd8;
   localparam logic [3:0] S_HWALK = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [ClrW-1:0]   clr_ff, clr_in;
   logic [ReqTypeW-1:0] op_ff, op_in;
   logic [VaW-1:0]    vid_ff, vid_in;
   logic [RankW-1:0]  k_ff, k_in;
   logic [CW-1:0]     oldc_ff, oldc_in;
   logic [CW-1:0]     newc_ff, newc_in;
   logic [BaW-1:0]    b_ff, b_in;
   logic [OfW-1:0]    off_ff, off_in;
   logic [SumW-1:0]   distinct_ff, distinct_in;
   logic              found_ff, found_in;
   logic [CountW-1:0] kth_ff, kth_in;
   logic [SumW-1:0]   bsum_ff [NumBuckets];

   // Bucket sum update requests.
   logic              bdec, binc;
   logic [BaW-1:0]    bdec_idx, binc_idx;

   // Memory ports.
   logic              cm_we;
   logic [VaW-1:0]    cm_wa, cm_ra;
   logic [CW-1:0]     cm_wd, cm_rd;
   logic              hm_we;
   logic [HaW-1:0]    hm_wa, hm_ra;
   logic [SumW-1:0]   hm_wd, hm_rd;

   result_type        res;

   frt_count_mem #(.NUM_VALUES(NUM_VALUES), .AW(VaW), .DW(CW)) u_count (
      .clock(clock), .wr_en(cm_we), .wr_addr(cm_wa), .wr_data(cm_wd),
      .rd_addr(cm_ra), .rd_data(cm_rd)
   );

   frt_hist_mem #(.DEPTH(MAX_COUNT), .AW(HaW), .DW(SumW)) u_hist (
      .clock(clock), .wr_en(hm_we), .wr_addr(hm_wa), .wr_data(hm_wd),
      .rd_addr(hm_ra), .rd_data(hm_rd)
   );

   function automatic logic [HaW-1:0] slot_of(input logic [CW-1:0] c);
      logic [CW-1:0] s;
      s = c - CW'(1);
      return HaW'(s);
   endfunction

   function automatic logic [BaW-1:0] bucket_of(input logic [CW-1:0] c);
      logic [CW-1:0] s;
      s = (c - CW'(1)) / CW'(BUCKET_LEN);
      return BaW'(s);
   endfunction

   logic [IdW-1:0] req_vid_ext;
   logic           req_vid_ok;
   logic [HaW:0]   hidx;
   logic [CW-1:0]  ccnt;

   assign req_vid_ext = IdW'(req_value_id);
   assign req_vid_ok  = req_vid_ext < IdW'(NUM_VALUES);
   assign hidx = (HaW+1)'(b_ff) * (HaW+1)'(BUCKET_LEN) + (HaW+1)'(off_ff);
   assign ccnt = cm_rd;

   // Sequencer: next state and memory accesses.
   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;   op_in = op_ff;
      vid_in = vid_ff;      k_in = k_ff;       oldc_in = oldc_ff;
      newc_in = newc_ff;    b_in = b_ff;       off_in = off_ff;
      distinct_in = distinct_ff; found_in = found_ff; kth_in = kth_ff;
      bdec = 1'b0;  binc = 1'b0;
      bdec_idx = bucket_of(oldc_ff);  binc_idx = bucket_of(newc_ff);
      cm_we = 1'b0; cm_wa = vid_ff; cm_wd = newc_ff; cm_ra = vid_ff;
      hm_we = 1'b0; hm_wa = slot_of(oldc_ff); hm_wd = hm_rd - SumW'(1);
      hm_ra = slot_of(oldc_ff);
      res = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cm_we = (clr_ff < ClrW'(NUM_VALUES));
            cm_wa = VaW'(clr_ff);
            cm_wd = '0;
            hm_we = (clr_ff < ClrW'(MAX_COUNT));
            hm_wa = HaW'(clr_ff);
            hm_wd = '0;
            clr_in = clr_ff + ClrW'(1);
            if (clr_ff == ClrW'(ClrN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = req_type;
               vid_in = VaW'(req_value_id);
               k_in = req_rank;
               found_in = 1'b0;
               kth_in = '0;
               b_in = '0;
               off_in = '0;
               cm_ra = VaW'(req_value_id);
               if ((req_type == REQ_ADD || req_type == REQ_REMOVE) && req_vid_ok) begin
                  state_in = S_CRD;
               end else if (req_type == REQ_QUERY && req_rank != '0 &&
                            {{(RankW > SumW ? 0 : SumW - RankW + 1){1'b0}}, req_rank} <=
                            {{(RankW > SumW ? RankW - SumW : 1){1'b0}}, distinct_ff}) begin
                  state_in = S_BWALK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_CRD: begin
            // Count word is now valid; decide old and new counts.
            oldc_in = ccnt;
            if (op_ff == REQ_ADD) begin
               newc_in = ccnt + CW'(1);
               state_in = (ccnt >= CW'(MAX_COUNT)) ? S_DONE :
                          ((ccnt == '0) ? S_NEW : S_OLD);
               if (ccnt == '0) begin
                  distinct_in = distinct_ff + SumW'(1);
               end
            end else begin
               newc_in = ccnt - CW'(1);
               state_in = (ccnt == '0) ? S_DONE : S_OLD;
               if (ccnt == CW'(1)) begin
                  distinct_in = distinct_ff - SumW'(1);
               end
            end
            if (!(op_ff == REQ_ADD && ccnt >= CW'(MAX_COUNT)) &&
                !(op_ff == REQ_REMOVE && ccnt == '0)) begin
               cm_we = 1'b1;
               cm_wd = (op_ff == REQ_ADD) ? ccnt + CW'(1) : ccnt - CW'(1);
            end
            hm_ra = slot_of(ccnt);
         end
         S_OLD: begin
            // Histogram entry of the old count read; write it back less one.
            hm_we = 1'b1;
            hm_wa = slot_of(oldc_ff);
            hm_wd = hm_rd - SumW'(1);
            bdec = 1'b1;
            state_in = S_OLDW;
         end
         S_OLDW: begin
            hm_ra = slot_of(newc_ff);
            state_in = (newc_ff == '0) ? S_DONE : S_NEW;
         end
         S_NEW: begin
            hm_ra = slot_of(newc_ff);
            state_in = S_NEWW;
         end
         S_NEWW: begin
            hm_we = 1'b1;
            hm_wa = slot_of(newc_ff);
            hm_wd = hm_rd + SumW'(1);
            binc = 1'b1;
            state_in = S_DONE;
         end
         S_BWALK: begin
            // Skip whole buckets until the rank falls inside one.
            if ({{(RankW > SumW ? 0 : SumW - RankW + 1){1'b0}}, k_ff} <=
                {{(RankW > SumW ? RankW - SumW : 1){1'b0}}, bsum_ff[b_ff]}) begin
               state_in = S_HRD;
            end else begin
               k_in = k_ff - RankW'(bsum_ff[b_ff]);
               b_in = b_ff + BaW'(1);
            end
         end
         S_HRD: begin
            hm_ra = HaW'(hidx);
            state_in = S_HWALK;
         end
         S_HWALK: begin
            // Compare the histogram entry read in the previous cycle.
            if ({{(RankW > SumW ? 0 : SumW - RankW + 1){1'b0}}, k_ff} <=
                {{(RankW > SumW ? RankW - SumW : 1){1'b0}}, hm_rd}) begin
               found_in = 1'b1;
               kth_in = CountW'(hidx + (HaW+1)'(1));
               state_in = S_DONE;
            end else begin
               k_in = k_ff - RankW'(hm_rd);
               off_in = off_ff + OfW'(1);
               state_in = S_HRD;
            end
         end
         S_DONE: begin
            res.valid = 1'b1;
            res.found = found_ff;
            res.kth_count = kth_ff;
            res.distinct_now = CountW'(distinct_ff);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         distinct_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         distinct_ff <= distinct_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      op_ff <= op_in;     vid_ff <= vid_in;   k_ff <= k_in;
      oldc_ff <= oldc_in; newc_ff <= newc_in; b_ff <= b_in;
      off_ff <= off_in;   found_ff <= found_in; kth_ff <= kth_in;
   end

   // Bucket sums in flip-flops, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumBuckets; i++) begin
            bsum_ff[i] <= '0;
         end
      end else begin
         if (bdec) begin
            bsum_ff[bdec_idx] <= bsum_ff[bdec_idx] - SumW'(1);
         end
         if (binc) begin
            bsum_ff[binc_idx] <= bsum_ff[binc_idx] + SumW'(1);
         end
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = res.valid;
   assign rsp_found        = res.found;
   assign rsp_kth_count    = res.kth_count;
   assign rsp_distinct_now = res.distinct_now;
endmodule

// ----- rtl/frt_checker.sv -----
// Port-level checker for the frequency rank tracker, bound to the top level.
module frt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_found,
   input logic [frt_pkg::CountW-1:0]   rsp_kth_count,
   input logic [frt_pkg::CountW-1:0]   rsp_distinct_now
);
   import frt_pkg::*;

   // A result never appears while the block is idle.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result without request");

   // A result ends the request.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");

   // Not found reports a zero count.
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_kth_count == '0))
      else $error("nonzero count when not found");

   // A found rank implies a nonzero distinct count and a nonzero reported count.
   a_found_nz: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_distinct_now != '0 && rsp_kth_count != '0))
      else $error("found with empty set");
endmodule

bind frequency_rank_tracker_unit frt_checker u_frt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_found(rsp_found),
   .rsp_kth_count(rsp_kth_count), .rsp_distinct_now(rsp_distinct_now)
);
